### sv/kic_pkg.sv
package kic_pkg;

    // Default sizes handed to the top level
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_BATCH_DEF   = 7;

    // Reply buffer depth and field widths
    localparam int REPLY_SIZE = 15;
    localparam int REPLY_AW   = 4;
    localparam int BATCH_W    = 3;
    localparam int PLEFT_W    = 5;

    // Action codes
    localparam logic [2:0] ACT_QUEUE  = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_ROW    = 3'd3;
    localparam logic [2:0] ACT_STATUS = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    // Host command codes
    localparam logic [3:0] CMD_STATUS = 4'd1;
    localparam logic [3:0] CMD_FETCH  = 4'd8;
    localparam logic [3:0] CMD_ROW    = 4'd9;
    localparam logic [3:0] CMD_LOAD   = 4'd10;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  modifiers;
        logic [7:0]  key_code;
        logic [15:0] char_code;
        logic [7:0]  data_byte;
        logic [2:0]  row_index;
        logic [7:0]  row_value;
        logic        key_held;
        logic        sound_active;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] read_char;
        logic [3:0]  reply_left;
        logic        key_dropped;
    } t_out_item;

    // One queued key as kept in the queue memory
    typedef struct packed {
        logic [2:0]  modifiers;
        logic [7:0]  key_code;
        logic [15:0] char_code;
    } t_qentry;

    // One reply byte with its character code
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] char_code;
    } t_reply;

    // Number of parameter bytes that follow a command byte
    function automatic logic [PLEFT_W-1:0] param_len(input logic [3:0] cmd);
        logic [PLEFT_W-1:0] len;
        case (cmd)
            CMD_ROW:  len = PLEFT_W'(1);
            CMD_LOAD: len = PLEFT_W'(16);
            default:  len = '0;
        endcase
        return len;
    endfunction

endpackage

### sv/kic_ram.sv
module kic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/keyboard_ipc_controller.sv
// Keyboard side of a peripheral controller, seen from the host.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one transaction
// per host or keyboard event: queue a key, write a host byte, read a reply
// byte, set a matrix row, set the held/sound flags, or clear the queue.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// result transaction for each input transaction, in order.
// Each action passes through the execute state and then the output state; a
// reply read adds a state for the registered reply data. A fetch command (8)
// that drains b keys loops through a queue read, a modifier byte write and a
// key code byte write per key, as the reply memory has a single write port.
// One transaction is worked on at a time; the next one is accepted as soon as
// the result is handed to the output register, even while that register is
// still stalled by the receiver. A stalled result holds its payload; the
// sequencer waits in its output state only if a second result is ready.
// Reset (synchronous, active low) empties the queue and the reply, clears the
// command state, the key matrix and both flags. The queue and reply memories
// are not cleared; only entries that were written are ever read back.
module keyboard_ipc_controller #(
    parameter int QUEUE_DEPTH = kic_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_BATCH   = kic_pkg::MAX_BATCH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kic_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kic_pkg::t_out_item  o_out_data
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int RW = kic_pkg::REPLY_AW;
    localparam int BW = kic_pkg::BATCH_W;
    localparam int PW = kic_pkg::PLEFT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RRD,
        S_QRD,
        S_WMOD,
        S_WCODE,
        S_OUT
    } t_state;

    // Registers
    t_state             r_state,    n_state;
    kic_pkg::t_in_item  r_item,     n_item;
    logic [QW-1:0]      r_head,     n_head;
    logic [QW-1:0]      r_tail,     n_tail;
    logic [3:0]         r_cmd,      n_cmd;
    logic [PW-1:0]      r_pleft,    n_pleft;
    logic [7:0]         r_fparam,   n_fparam;
    logic [RW-1:0]      r_rcount,   n_rcount;
    logic [RW-1:0]      r_rpos,     n_rpos;
    logic [7:0]         r_matrix    [8];
    logic [7:0]         n_matrix    [8];
    logic               r_held,     n_held;
    logic               r_sound,    n_sound;
    logic [BW-1:0]      r_batch,    n_batch;
    logic [RW-1:0]      r_wptr,     n_wptr;
    logic [7:0]         r_res_data, n_res_data;
    logic [15:0]        r_res_char, n_res_char;
    logic               r_res_drop, n_res_drop;
    logic               r_out_valid, n_out_valid;
    kic_pkg::t_out_item r_out,      n_out;

    // Memory ports
    logic               w_q_wr_en;
    kic_pkg::t_qentry   w_q_wr_data;
    logic               w_q_rd_en;
    kic_pkg::t_qentry   w_q_rd_data;
    logic               w_r_wr_en;
    logic [RW-1:0]      w_r_wr_addr;
    kic_pkg::t_reply    w_r_wr_data;
    logic               w_r_rd_en;
    kic_pkg::t_reply    w_r_rd_data;

    // Queue bookkeeping
    logic [QW-1:0]      w_next_tail;
    logic [QW-1:0]      w_next_head;
    logic               w_full;
    logic [QW:0]        w_qcount;
    logic [BW-1:0]      w_batch;

    // Command decode for a host byte write
    logic [3:0]         w_cmd;
    logic [PW-1:0]      w_pleft;
    logic [7:0]         w_fparam;

    kic_ram #(
        .WIDTH ($bits(kic_pkg::t_qentry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_q_wr_data),
        .i_rd_en   (w_q_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (w_q_rd_data)
    );

    kic_ram #(
        .WIDTH ($bits(kic_pkg::t_reply)),
        .DEPTH (kic_pkg::REPLY_SIZE)
    ) u_reply_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_r_wr_en),
        .i_wr_addr (w_r_wr_addr),
        .i_wr_data (w_r_wr_data),
        .i_rd_en   (w_r_rd_en),
        .i_rd_addr (r_rpos),
        .o_rd_data (w_r_rd_data)
    );

    // Wrap pointers at the queue depth, which need not be a power of two
    assign w_next_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_next_head = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_full      = (w_next_tail == r_head);

    always_comb begin
        if (r_tail >= r_head) begin
            w_qcount = {1'b0, r_tail} - {1'b0, r_head};
        end else begin
            w_qcount = {1'b0, r_tail} + (QW+1)'(QUEUE_DEPTH) - {1'b0, r_head};
        end
    end

    assign w_batch = (w_qcount > (QW+1)'(MAX_BATCH)) ? BW'(MAX_BATCH) : w_qcount[BW-1:0];

    // Parameter bytes go to the pending command; any other byte starts a new one
    always_comb begin
        w_cmd    = r_cmd;
        w_fparam = r_fparam;
        if (r_pleft != '0) begin
            if (r_pleft == kic_pkg::param_len(r_cmd)) begin
                w_fparam = r_item.data_byte;
            end
            w_pleft = r_pleft - 1'b1;
        end else begin
            w_cmd   = r_item.data_byte[3:0];
            w_pleft = kic_pkg::param_len(w_cmd);
        end
    end

    assign w_q_wr_data = '{modifiers: r_item.modifiers,
                           key_code:  r_item.key_code,
                           char_code: r_item.char_code};

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cmd       = r_cmd;
        n_pleft     = r_pleft;
        n_fparam    = r_fparam;
        n_rcount    = r_rcount;
        n_rpos      = r_rpos;
        n_matrix    = r_matrix;
        n_held      = r_held;
        n_sound     = r_sound;
        n_batch     = r_batch;
        n_wptr      = r_wptr;
        n_res_data  = r_res_data;
        n_res_char  = r_res_char;
        n_res_drop  = r_res_drop;
        n_out       = r_out;
        // Drop the result once the receiver takes it
        n_out_valid = r_out_valid && i_out_stall;

        w_q_wr_en   = 1'b0;
        w_q_rd_en   = 1'b0;
        w_r_wr_en   = 1'b0;
        w_r_wr_addr = '0;
        w_r_wr_data = '0;
        w_r_rd_en   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_data = '0;
                n_res_char = '0;
                n_res_drop = 1'b0;
                n_state    = S_OUT;
                case (r_item.action)
                    kic_pkg::ACT_QUEUE: begin
                        if (w_full) begin
                            n_res_drop = 1'b1;
                        end else begin
                            w_q_wr_en = 1'b1;
                            n_tail    = w_next_tail;
                        end
                    end
                    kic_pkg::ACT_WRITE: begin
                        n_cmd    = w_cmd;
                        n_pleft  = w_pleft;
                        n_fparam = w_fparam;
                        if (w_pleft == '0) begin
                            // Any completed command discards the unread reply
                            n_rpos   = '0;
                            n_rcount = '0;
                            case (w_cmd)
                                kic_pkg::CMD_STATUS: begin
                                    w_r_wr_en   = 1'b1;
                                    w_r_wr_data = '{data: {6'b0, r_sound,
                                                           (r_head != r_tail) || r_held},
                                                    char_code: 16'h0};
                                    n_rcount    = RW'(1);
                                end
                                kic_pkg::CMD_FETCH: begin
                                    w_r_wr_en   = 1'b1;
                                    w_r_wr_data = '{data: {4'b0, r_held, w_batch},
                                                    char_code: 16'h0};
                                    n_rcount    = RW'(1) + {w_batch, 1'b0};
                                    n_batch     = w_batch;
                                    n_wptr      = RW'(1);
                                    if (w_batch != '0) begin
                                        n_state = S_QRD;
                                    end
                                end
                                kic_pkg::CMD_ROW: begin
                                    w_r_wr_en   = 1'b1;
                                    w_r_wr_data = '{data: r_matrix[w_fparam[2:0]],
                                                    char_code: 16'h0};
                                    n_rcount    = RW'(1);
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    kic_pkg::ACT_READ: begin
                        if (r_rcount != '0 && r_rpos < RW'(kic_pkg::REPLY_SIZE)) begin
                            w_r_rd_en = 1'b1;
                            n_rpos    = r_rpos + 1'b1;
                            n_rcount  = r_rcount - 1'b1;
                            n_state   = S_RRD;
                        end
                    end
                    kic_pkg::ACT_ROW: begin
                        n_matrix[r_item.row_index] = r_item.row_value;
                    end
                    kic_pkg::ACT_STATUS: begin
                        n_held  = r_item.key_held;
                        n_sound = r_item.sound_active;
                    end
                    kic_pkg::ACT_CLEAR: begin
                        n_head = '0;
                        n_tail = '0;
                        n_held = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            S_RRD: begin
                n_res_data = w_r_rd_data.data;
                n_res_char = w_r_rd_data.char_code;
                n_state    = S_OUT;
            end

            // Pop one key: read at head, then write its two reply bytes
            S_QRD: begin
                w_q_rd_en = 1'b1;
                n_head    = w_next_head;
                n_state   = S_WMOD;
            end

            S_WMOD: begin
                w_r_wr_en   = 1'b1;
                w_r_wr_addr = r_wptr;
                w_r_wr_data = '{data: {5'b0, w_q_rd_data.modifiers},
                                char_code: w_q_rd_data.char_code};
                n_wptr      = r_wptr + 1'b1;
                n_state     = S_WCODE;
            end

            S_WCODE: begin
                w_r_wr_en   = 1'b1;
                w_r_wr_addr = r_wptr;
                w_r_wr_data = '{data: w_q_rd_data.key_code,
                                char_code: w_q_rd_data.char_code};
                n_wptr      = r_wptr + 1'b1;
                n_batch     = r_batch - 1'b1;
                n_state     = (r_batch == BW'(1)) ? S_OUT : S_QRD;
            end

            S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = '{read_data:   r_res_data,
                                    read_char:   r_res_char,
                                    reply_left:  r_rcount,
                                    key_dropped: r_res_drop};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_item      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_cmd       <= '0;
            r_pleft     <= '0;
            r_fparam    <= '0;
            r_rcount    <= '0;
            r_rpos      <= '0;
            r_matrix    <= '{default: '0};
            r_held      <= 1'b0;
            r_sound     <= 1'b0;
            r_batch     <= '0;
            r_wptr      <= '0;
            r_res_data  <= '0;
            r_res_char  <= '0;
            r_res_drop  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cmd       <= n_cmd;
            r_pleft     <= n_pleft;
            r_fparam    <= n_fparam;
            r_rcount    <= n_rcount;
            r_rpos      <= n_rpos;
            r_matrix    <= n_matrix;
            r_held      <= n_held;
            r_sound     <= n_sound;
            r_batch     <= n_batch;
            r_wptr      <= n_wptr;
            r_res_data  <= n_res_data;
            r_res_char  <= n_res_char;
            r_res_drop  <= n_res_drop;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Unread reply never runs past the end of the reply buffer
    a_reply_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rcount} + {1'b0, r_rpos}) <= (RW+1)'(kic_pkg::REPLY_SIZE))
        else $error("reply count and position exceed reply buffer");

    // Queue pointers stay inside the queue
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_head} < (QW+1)'(QUEUE_DEPTH)) && ({1'b0, r_tail} < (QW+1)'(QUEUE_DEPTH)))
        else $error("queue pointer out of range");

    // A dropped key leaves the tail alone
    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_item.action == kic_pkg::ACT_QUEUE && w_full)
        |=> (r_tail == $past(r_tail)))
        else $error("tail moved on a full queue");

    // The fetch loop only runs with keys left to copy
    a_batch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRD || r_state == S_WMOD || r_state == S_WCODE) |-> (r_batch != '0))
        else $error("fetch loop running with empty batch");

    // A pop never passes the tail
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRD) |-> (r_head != r_tail))
        else $error("pop from empty queue");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    // Actions the block has no use for; it must leave its state alone
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    // A command with no parameters and no reply
    localparam logic [3:0] CMD_UNUSED = 4'd15;
    // Bit added to the fetch count byte while a key is held
    localparam logic [7:0] HELD_FLAG = 8'h08;

    localparam int KEY_SLOTS    = kic_pkg::QUEUE_DEPTH_DEF;
    localparam int BATCH_LIMIT  = kic_pkg::MAX_BATCH_DEF;
    localparam int REPLY_SLOTS  = kic_pkg::REPLY_SIZE;
    localparam int TARGET_ITEMS = 1250;
    localparam int TAIL_EVENTS  = 150;   // no idling once this few are left to send
    localparam int HOLD_AFTER   = 300;   // results before the long receiver hold
    localparam int HOLD_CYCLES  = 250;
    localparam int IDLE_LIMIT   = 3000;  // watchdog: cycles with no transaction at all
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        kic_pkg::t_in_item ev;
        logic              settle;   // wait for every pending result before sending
    } t_host_event;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    kic_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    kic_pkg::t_out_item out_data;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    always #4 clk = ~clk;

    keyboard_ipc_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Controller state as the predictor sees it
    // ------------------------------------------------------------------
    kic_pkg::t_qentry key_slots [KEY_SLOTS];
    int          slot_rd;
    int          slot_wr;
    logic [3:0]  host_cmd;
    int          args_due;
    logic [7:0]  first_arg;
    logic [7:0]  reply_data [REPLY_SLOTS];
    logic [15:0] reply_code [REPLY_SLOTS];
    int          reply_len;
    int          reply_at;
    logic [7:0]  rows [8];
    logic        held;
    logic        sound;

    t_host_event        host_events [$];
    kic_pkg::t_out_item due_results [$];

    int        host_total = 0;
    int        events_accepted = 0;
    int        planned = 0;
    bit        settle_next = 1'b0;
    bit        tail_phase = 1'b0;
    bit        send_gappy = 1'b1;
    bit        recv_gappy = 1'b1;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;
    kic_pkg::t_out_item want;

    // Parameter bytes that follow a command byte
    function automatic int arg_count(logic [3:0] cmd);
        case (cmd)
            kic_pkg::CMD_ROW:  return 1;
            kic_pkg::CMD_LOAD: return 16;
            default:           return 0;
        endcase
    endfunction

    // Advance the predicted state by one transaction and return its result
    function automatic kic_pkg::t_out_item step_controller(kic_pkg::t_in_item ev);
        kic_pkg::t_out_item res;
        int        batch;
        int        n;
        res = '0;
        case (ev.action)
            kic_pkg::ACT_QUEUE: begin
                // One slot always stays free; a key that finds no room is dropped
                if ((slot_wr + 1) % KEY_SLOTS == slot_rd) begin
                    res.key_dropped = 1'b1;
                end else begin
                    key_slots[slot_wr] = {ev.modifiers, ev.key_code, ev.char_code};
                    slot_wr = (slot_wr + 1) % KEY_SLOTS;
                end
            end
            kic_pkg::ACT_WRITE: begin
                if (args_due > 0) begin
                    // Keep only the first parameter byte
                    if (args_due == arg_count(host_cmd)) first_arg = ev.data_byte;
                    args_due--;
                end else begin
                    host_cmd = ev.data_byte[3:0];
                    args_due = arg_count(host_cmd);
                end
                if (args_due == 0) begin
                    // Command complete: build a fresh reply, drop the old one
                    n = 0;
                    case (host_cmd)
                        kic_pkg::CMD_STATUS: begin
                            reply_data[0] = {6'b0, sound, (slot_rd != slot_wr) || held};
                            reply_code[0] = '0;
                            n = 1;
                        end
                        kic_pkg::CMD_FETCH: begin
                            batch = (slot_wr - slot_rd + KEY_SLOTS) % KEY_SLOTS;
                            if (batch > BATCH_LIMIT) batch = BATCH_LIMIT;
                            reply_data[0] = 8'(batch) | (held ? HELD_FLAG : 8'h00);
                            reply_code[0] = '0;
                            n = 1;
                            for (int k = 0; k < batch && n + 1 < REPLY_SLOTS; k++) begin
                                reply_data[n]     = {5'b0, key_slots[slot_rd].modifiers};
                                reply_code[n]     = key_slots[slot_rd].char_code;
                                reply_data[n + 1] = key_slots[slot_rd].key_code;
                                reply_code[n + 1] = key_slots[slot_rd].char_code;
                                n += 2;
                                slot_rd = (slot_rd + 1) % KEY_SLOTS;
                            end
                        end
                        kic_pkg::CMD_ROW: begin
                            reply_data[0] = rows[first_arg[2:0]];
                            reply_code[0] = '0;
                            n = 1;
                        end
                        default: n = 0;
                    endcase
                    reply_len = n;
                    reply_at  = 0;
                end
            end
            kic_pkg::ACT_READ: begin
                if (reply_len > 0 && reply_at < REPLY_SLOTS) begin
                    res.read_data = reply_data[reply_at];
                    res.read_char = reply_code[reply_at];
                    reply_at++;
                    reply_len--;
                end
            end
            kic_pkg::ACT_ROW: rows[ev.row_index] = ev.row_value;
            kic_pkg::ACT_STATUS: begin
                held  = ev.key_held;
                sound = ev.sound_active;
            end
            kic_pkg::ACT_CLEAR: begin
                // Empty the key queue; command, reply, rows and sound stay
                slot_rd = 0;
                slot_wr = 0;
                held    = 1'b0;
            end
            default: ;
        endcase
        res.reply_left = 4'(reply_len);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < 100) $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building: every field random, then the ones that matter set
    // ------------------------------------------------------------------
    function automatic kic_pkg::t_in_item random_event(logic [2:0] act);
        logic [63:0]       bits;
        kic_pkg::t_in_item ev;
        bits = {$urandom, $urandom};
        ev = bits[$bits(kic_pkg::t_in_item)-1:0];
        ev.action = act;
        return ev;
    endfunction

    task automatic push_event(kic_pkg::t_in_item ev);
        host_events.push_back({ev, settle_next});
        settle_next = 1'b0;
        // Spare actions are ignored by the block; leave them out of the count
        if (ev.action <= kic_pkg::ACT_CLEAR) planned++;
    endtask

    task automatic send_byte(logic [7:0] b);
        kic_pkg::t_in_item ev;
        ev = random_event(kic_pkg::ACT_WRITE);
        ev.data_byte = b;
        push_event(ev);
    endtask

    task automatic read_back(int n);
        repeat (n) push_event(random_event(kic_pkg::ACT_READ));
    endtask

    task automatic key_press();
        push_event(random_event(kic_pkg::ACT_QUEUE));
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued transactions, hold them while stalled
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            tail_phase <= (host_events.size() < TAIL_EVENTS);
            if (in_fire) begin
                due_results.push_back(step_controller(in_data));
                events_accepted++;
                if ($urandom_range(0, 59) == 0) send_gappy = !send_gappy;
            end
            // Change the payload only when nothing is on offer or it just went
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (host_events.size() == 0 ||
                             (host_events[0].settle && due_results.size() != 0)) begin
                    // Pause until every pending result has come back
                    in_valid <= 1'b0;
                end else if (!tail_phase && send_gappy && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= host_events[0].ev;
                    in_valid <= 1'b1;
                    void'(host_events.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, drive stall
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing pending", out_data));
                end else begin
                    want = due_results.pop_front();
                    if (out_data.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  out_data.read_data, want.read_data));
                    if (out_data.read_char !== want.read_char)
                        report_mismatch($sformatf("read_char %h, want %h",
                                                  out_data.read_char, want.read_char));
                    if (out_data.reply_left !== want.reply_left)
                        report_mismatch($sformatf("reply_left %0d, want %0d",
                                                  out_data.reply_left, want.reply_left));
                    if (out_data.key_dropped !== want.key_dropped)
                        report_mismatch($sformatf("key_dropped %b, want %b",
                                                  out_data.key_dropped, want.key_dropped));
                end
                if ($urandom_range(0, 59) == 0) recv_gappy = !recv_gappy;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // Long hold: let the block back up and stall its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else if (!tail_phase && recv_gappy && $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel
    always @(posedge clk) begin
        if (!rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int                pick;
        int                seq;
        int                nargs;
        kic_pkg::t_in_item ev;

        // Reset values of the predicted state
        slot_rd   = 0;
        slot_wr   = 0;
        host_cmd  = '0;
        args_due  = 0;
        first_arg = '0;
        reply_len = 0;
        reply_at  = 0;
        held      = 1'b0;
        sound     = 1'b0;
        foreach (rows[r]) rows[r] = '0;
        foreach (reply_code[r]) reply_code[r] = '0;
        foreach (reply_data[r]) reply_data[r] = '0;

        // Directed: read with no reply, status with empty queue
        read_back(1);
        send_byte({4'hF, kic_pkg::CMD_STATUS});
        read_back(2);
        // Status with key held and sound on
        ev = random_event(kic_pkg::ACT_STATUS);
        ev.key_held = 1'b1;
        ev.sound_active = 1'b1;
        push_event(ev);
        send_byte({4'h0, kic_pkg::CMD_STATUS});
        read_back(1);
        // Row 7 all ones, fetched with a parameter above 7
        ev = random_event(kic_pkg::ACT_ROW);
        ev.row_index = 3'd7;
        ev.row_value = 8'hFF;
        push_event(ev);
        send_byte({4'h5, kic_pkg::CMD_ROW});
        send_byte(8'hFF);
        read_back(1);
        // Keys at both extremes, then a fetch that is only partly read back
        ev = random_event(kic_pkg::ACT_QUEUE);
        {ev.modifiers, ev.key_code, ev.char_code} = '1;
        push_event(ev);
        ev = random_event(kic_pkg::ACT_QUEUE);
        {ev.modifiers, ev.key_code, ev.char_code} = '0;
        push_event(ev);
        send_byte({4'hA, kic_pkg::CMD_FETCH});
        read_back(3);
        // A reply-less command discards what was left unread
        send_byte({4'h0, CMD_UNUSED});
        read_back(1);
        push_event(random_event(ACT_SPARE_6));
        push_event(random_event(ACT_SPARE_7));
        // Clear drops the held flag but keeps sound
        push_event(random_event(kic_pkg::ACT_CLEAR));
        send_byte({4'h3, kic_pkg::CMD_STATUS});
        read_back(1);

        // Fill the queue past its limit, then random sequences
        repeat (KEY_SLOTS + 2) key_press();
        seq = 0;
        while (planned < TARGET_ITEMS) begin
            if (seq == 20 || $urandom_range(0, 39) == 0) settle_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                repeat ($urandom_range(1, 8)) key_press();
            end else if (pick < 50) begin
                send_byte({4'($urandom), kic_pkg::CMD_FETCH});
                read_back($urandom_range(0, 16));
            end else if (pick < 60) begin
                send_byte({4'($urandom), kic_pkg::CMD_STATUS});
                read_back($urandom_range(0, 2));
            end else if (pick < 68) begin
                push_event(random_event(kic_pkg::ACT_ROW));
                send_byte({4'($urandom), kic_pkg::CMD_ROW});
                send_byte(8'($urandom));
                read_back($urandom_range(1, 2));
            end else if (pick < 74) begin
                // Mostly complete loads, some cut short or overrun
                send_byte({4'($urandom), kic_pkg::CMD_LOAD});
                nargs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 16;
                repeat (nargs) send_byte(8'($urandom));
                read_back($urandom_range(0, 1));
            end else if (pick < 80) begin
                push_event(random_event(kic_pkg::ACT_STATUS));
            end else if (pick < 83) begin
                push_event(random_event(kic_pkg::ACT_CLEAR));
            end else if (pick < 86) begin
                repeat ($urandom_range(KEY_SLOTS - 4, KEY_SLOTS + 2)) key_press();
            end else if (pick < 94) begin
                send_byte(8'($urandom));
                read_back($urandom_range(0, 2));
            end else begin
                repeat ($urandom_range(1, 4)) push_event(random_event(3'($urandom)));
            end
            seq++;
        end
        host_total = host_events.size();

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to go in and every result to come out
        do @(posedge clk);
        while (events_accepted != host_total || due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/kic_pkg.sv
sv/kic_ram.sv
sv/keyboard_ipc_controller.sv
test/tb.sv
